FILE: src/mtsg_pkg.sv
// Shared constants, command and status types, and word functions for the
// MT19937 seeded generator. No dependencies.
`default_nettype none

package mtsg_pkg;

    localparam int unsigned WORDS  = 624;
    localparam int unsigned SHIFT  = 397;
    localparam int unsigned IDX_W  = 10;
    localparam int unsigned SEED_W = 14;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned M_PAD_W   = M_TDATA_W - DATA_W - SEED_W;

    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(WORDS - 1);
    localparam logic [IDX_W-1:0] IDX_FULL     = IDX_W'(WORDS);
    localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(WORDS + 1);
    localparam logic [IDX_W-1:0] IDX_SHIFT    = IDX_W'(SHIFT);
    localparam logic [IDX_W-1:0] IDX_WRAP     = IDX_W'(WORDS - SHIFT);

    localparam logic [DATA_W-1:0] TWIST_XOR = 32'h9908_b0df;
    localparam logic [DATA_W-1:0] INIT_MUL = 32'd1812433253;
    localparam logic [DATA_W-1:0] TEMPER_B = 32'h9d2c_5680;
    localparam logic [DATA_W-1:0] TEMPER_C = 32'hefc6_0000;

    localparam logic [SEED_W-1:0] SEED_MAX     = 14'd9999;
    localparam logic [SEED_W-1:0] DEFAULT_SEED = 14'd5489;

    localparam logic MODE_NEXT   = 1'b0;
    localparam logic MODE_RESEED = 1'b1;

    typedef struct packed {
        logic              reseed;
        logic [SEED_W-1:0] seed;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic [IDX_W-1:0]  word_index;
        logic [SEED_W-1:0] last_seed;
    } back_stat_t;

    // Output tempering of one state word.
    function automatic logic [DATA_W-1:0] temper(input logic [DATA_W-1:0] w);
        logic [DATA_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // New value of word k from old word k, word k+1 and word k+397.
    function automatic logic [DATA_W-1:0] twist_word(input logic [DATA_W-1:0] cur,
                                                     input logic [DATA_W-1:0] nxt,
                                                     input logic [DATA_W-1:0] far);
        logic [DATA_W-1:0] y;
        y = {cur[DATA_W-1], nxt[DATA_W-2:0]};
        return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
    endfunction

endpackage

`default_nettype wire

FILE: src/mtsg_front.sv
// Input side of the generator: takes beats, classifies them and clamps the seed.
// Depends on mtsg_pkg.
`default_nettype none

module mtsg_front (
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [31:0]         s_tdata,
    input  wire logic                s_tuser,
    input  wire mtsg_pkg::fifo_stat_t fifo_stat,
    output logic                     push,
    output mtsg_pkg::cmd_t           push_cmd
);

    assign s_tready = !fifo_stat.full;
    assign push     = s_tvalid && !fifo_stat.full;

    always_comb begin
        push_cmd.reseed = (s_tuser == mtsg_pkg::MODE_RESEED);
        // Seeds above the limit saturate.
        if (s_tdata > 32'(mtsg_pkg::SEED_MAX)) begin
            push_cmd.seed = mtsg_pkg::SEED_MAX;
        end else begin
            push_cmd.seed = s_tdata[mtsg_pkg::SEED_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: src/mtsg_cmd_fifo.sv
// Two-entry command queue between the input side and the generator engine.
// Depends on mtsg_pkg.
`default_nettype none

module mtsg_cmd_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire mtsg_pkg::cmd_t       push_cmd,
    input  wire logic                 pop,
    output mtsg_pkg::cmd_t            pop_cmd,
    output mtsg_pkg::fifo_stat_t      stat
);

    mtsg_pkg::cmd_t entries_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: src/mtsg_back.sv
// Generator engine: state memory, seeding sweep, twist sweep, tempering and
// the output register. Depends on mtsg_pkg.
`default_nettype none

module mtsg_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cmd_valid,
    input  wire mtsg_pkg::cmd_t       cmd,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [mtsg_pkg::M_TDATA_W-1:0] m_tdata,
    output mtsg_pkg::back_stat_t      stat
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SEED    = 6'b000010,
        ST_PRIME   = 6'b000100,
        ST_TW_RD   = 6'b001000,
        ST_TW_WR   = 6'b010000,
        ST_RD_WAIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [mtsg_pkg::IDX_W-1:0]  k_reg, k_next;
    logic [mtsg_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [mtsg_pkg::SEED_W-1:0] last_seed_reg, last_seed_next;
    logic [mtsg_pkg::DATA_W-1:0] x_reg, x_next;
    logic [mtsg_pkg::DATA_W-1:0] cur_reg, cur_next;
    logic                        out_valid_reg, out_valid_next;
    logic [mtsg_pkg::DATA_W-1:0] out_word_reg, out_word_next;
    logic [mtsg_pkg::SEED_W-1:0] out_seed_reg, out_seed_next;

    logic [mtsg_pkg::DATA_W-1:0] mem [mtsg_pkg::WORDS];
    logic [mtsg_pkg::DATA_W-1:0] rdata_a_reg, rdata_b_reg;

    logic                        rd_en_a, rd_en_b, wr_en;
    logic [mtsg_pkg::IDX_W-1:0]  rd_addr_a, rd_addr_b, wr_addr;
    logic [mtsg_pkg::DATA_W-1:0] wr_data;

    logic [mtsg_pkg::IDX_W-1:0]  k_plus1, k_far;
    logic [mtsg_pkg::DATA_W-1:0] x_mix;
    logic [mtsg_pkg::DATA_W-1:0] seed_prod;

    // Neighbor addresses of word k, taken modulo the state size.
    assign k_plus1 = (k_reg == mtsg_pkg::IDX_LAST) ? '0 : k_reg + 10'd1;
    assign k_far   = (k_reg >= mtsg_pkg::IDX_WRAP) ? k_reg - mtsg_pkg::IDX_WRAP
                                                   : k_reg + mtsg_pkg::IDX_SHIFT;

    // Only the low word of the product is kept by the recurrence.
    assign x_mix     = x_reg ^ (x_reg >> 30);
    assign seed_prod = mtsg_pkg::INIT_MUL * x_mix;

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {{mtsg_pkg::M_PAD_W{1'b0}}, out_seed_reg, out_word_reg};
    assign stat.word_index = idx_reg;
    assign stat.last_seed  = last_seed_reg;

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        last_seed_next = last_seed_reg;
        x_next         = x_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_seed_next  = out_seed_reg;
        pop            = 1'b0;
        rd_en_a        = 1'b0;
        rd_en_b        = 1'b0;
        rd_addr_a      = k_plus1;
        rd_addr_b      = k_far;
        wr_en          = 1'b0;
        wr_addr        = k_reg;
        wr_data        = x_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.reseed) begin
                        pop            = 1'b1;
                        x_next         = 32'(cmd.seed);
                        last_seed_next = cmd.seed;
                        k_next         = '0;
                        state_next     = ST_SEED;
                    end else if (idx_reg == mtsg_pkg::IDX_UNSEEDED) begin
                        // First request without a reseed: load the default
                        // seed, then come back here to twist.
                        x_next         = 32'(mtsg_pkg::DEFAULT_SEED);
                        last_seed_next = mtsg_pkg::DEFAULT_SEED;
                        k_next         = '0;
                        state_next     = ST_SEED;
                    end else if (idx_reg == mtsg_pkg::IDX_FULL) begin
                        state_next = ST_PRIME;
                    end else begin
                        pop        = 1'b1;
                        rd_en_a    = 1'b1;
                        rd_addr_a  = idx_reg;
                        state_next = ST_RD_WAIT;
                    end
                end
            end
            ST_SEED: begin
                wr_en   = 1'b1;
                wr_data = x_reg;
                x_next  = seed_prod + 32'(k_reg) + 32'd1;
                if (k_reg == mtsg_pkg::IDX_LAST) begin
                    idx_next   = mtsg_pkg::IDX_FULL;
                    state_next = ST_IDLE;
                end else begin
                    k_next = k_reg + 10'd1;
                end
            end
            ST_PRIME: begin
                rd_en_a    = 1'b1;
                rd_addr_a  = '0;
                k_next     = '0;
                state_next = ST_TW_RD;
            end
            ST_TW_RD: begin
                if (k_reg == '0) begin
                    cur_next = rdata_a_reg;
                end
                rd_en_a    = 1'b1;
                rd_en_b    = 1'b1;
                state_next = ST_TW_WR;
            end
            ST_TW_WR: begin
                wr_en    = 1'b1;
                wr_data  = mtsg_pkg::twist_word(cur_reg, rdata_a_reg, rdata_b_reg);
                cur_next = rdata_a_reg;
                if (k_reg == mtsg_pkg::IDX_LAST) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    k_next     = k_reg + 10'd1;
                    state_next = ST_TW_RD;
                end
            end
            ST_RD_WAIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_word_next  = mtsg_pkg::temper(rdata_a_reg);
                    out_seed_next  = last_seed_reg;
                    idx_next       = idx_reg + 10'd1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            idx_reg       <= mtsg_pkg::IDX_UNSEEDED;
            last_seed_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            idx_reg       <= idx_next;
            last_seed_reg <= last_seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        cur_reg      <= cur_next;
        out_word_reg <= out_word_next;
        out_seed_reg <= out_seed_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en_a) begin
            rdata_a_reg <= mem[rd_addr_a];
        end
        if (rd_en_b) begin
            rdata_b_reg <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

FILE: src/mt19937_seeded_generator.sv
// A next beat passes the command queue, memory read register and output register to m_
// when no twist is due. A twist sweep (after a reseed and every 624 words) makes one
// priming read, then a read and a write state per word through the single write port of
// the state memory. A reseed writes all 624 words in a seeding sweep; the first request
// without a reseed runs it too. A word is read and tempered before the next is taken.
// Reset: synchronous, active low; the generator comes up unseeded, the queue empty.
`default_nettype none

module mt19937_seeded_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] seed
    input  wire logic        s_tuser,   // [0] mode: 0 next word, 1 reseed
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // [31:0] rand_word, [45:32] loaded_seed, [47:46] zero
);

    // The front side clamps the seed and tags the beat as a reseed or a
    // word request. Commands wait in a two-entry queue, so up to two input beats
    // are accepted while the engine is busy seeding or twisting.
    logic                  push;
    mtsg_pkg::cmd_t        push_cmd;
    logic                  pop;
    mtsg_pkg::cmd_t        pop_cmd;
    mtsg_pkg::fifo_stat_t  fifo_stat;
    mtsg_pkg::back_stat_t  back_stat;

    mtsg_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    mtsg_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (fifo_stat)
    );

    // The engine owns the 624-word state memory. It only pops a request
    // once it can serve it: a pending twist or default seeding runs first,
    // and the word is loaded into the output register once that register
    // is free or being drained in the same cycle.
    mtsg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!fifo_stat.empty),
        .cmd       (pop_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .stat      (back_stat)
    );

    // The engine never pops from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_stat.empty)
        else $error("command popped from empty queue");

    // An accepted beat is held in the queue on the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !fifo_stat.empty)
        else $error("accepted beat lost from queue");

    // The word index never goes past the unseeded marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.word_index <= mtsg_pkg::IDX_UNSEEDED)
        else $error("word index out of range");

    // The recorded seed is always a clamped one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.last_seed <= mtsg_pkg::SEED_MAX)
        else $error("recorded seed above limit");

    // A delivered seed is always a clamped one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[45:32] <= mtsg_pkg::SEED_MAX))
        else $error("loaded seed above limit");

endmodule

`default_nettype wire
